/* design/assert_macros.svh */
// Assertion macros shared by the token lexer modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* design/rtftl_pkg.sv */
// Package of the RTF token lexer: token kinds, the token record passed
// from the front end to the back end, and byte classification helpers.
package rtftl_pkg;

  typedef enum logic [3:0] {
    K_GRPSTART  = 4'd0,
    K_GRPEND    = 4'd1,
    K_TEXTCHAR  = 4'd2,
    K_TEXTEND   = 4'd3,
    K_NAMECHAR  = 4'd4,
    K_KWEND     = 4'd5,
    K_ESCAPED   = 4'd6,
    K_HEX       = 4'd7,
    K_CTLSYM    = 4'd8,
    K_TAB       = 4'd9,
    K_PAR       = 4'd10,
    K_EMPTYTEXT = 4'd11,
    K_EOF       = 4'd12
  } kind_e;

  localparam int OUT_PARAM_W = 32;
  localparam int FIFO_DEPTH  = 4;

  // Up to two tokens caused by one input byte; the parameter belongs to
  // whichever token is a keyword end or a hex byte.
  typedef struct packed {
    logic                          two;
    kind_e                         kind0;
    logic [7:0]                    char0;
    kind_e                         kind1;
    logic [7:0]                    char1;
    logic                          has_param;
    logic signed [OUT_PARAM_W-1:0] param;
  } token_rec_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Non-hex characters count as nibble zero.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
    end
    return t[3:0];
  endfunction

endpackage

/* design/rtftl_if.sv */
// Valid/ready channel interfaces of the RTF token lexer.
// Depends on nothing; the top level and its front and back ends use them.
interface rtftl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface rtftl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [7:0]         char_value;
  logic               has_param;
  logic signed [31:0] param;
  logic               last;

  modport source (output valid, kind, char_value, has_param, param, last, input ready);
  modport sink (input valid, kind, char_value, has_param, param, last, output ready);
endinterface

/* design/rtftl_front.sv */
// Front end of the RTF token lexer: lexing state machine that classifies
// each byte and pushes a record of its tokens. Uses rtftl_pkg, rtftl_if.
module rtftl_front #(
  parameter int PARAM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtftl_in_if.sink              in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output rtftl_pkg::token_rec_t rec_o
);
  import rtftl_pkg::*;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_TEXT  = 3'd1;
  localparam logic [2:0] M_BSL   = 3'd2;
  localparam logic [2:0] M_NAME  = 3'd3;
  localparam logic [2:0] M_PARAM = 3'd4;
  localparam logic [2:0] M_HEX1  = 3'd5;
  localparam logic [2:0] M_HEX2  = 3'd6;

  logic [2:0]             mode_q, mode_d;
  logic [PARAM_WIDTH-1:0] acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [3:0]             hi_q, hi_d;

  logic       accept;
  logic [7:0] b;
  logic [1:0] n;
  token_rec_t rec;

  // Handling of a byte seen between tokens.
  logic       idle_n;
  kind_e      idle_kind;
  logic [7:0] idle_char;
  logic [2:0] idle_mode;

  // Keyword end as it would close the current keyword.
  logic                          kw_hp;
  logic [PARAM_WIDTH-1:0]        kw_mag;
  logic signed [OUT_PARAM_W-1:0] kw_prm;

  // Hex byte assembled from the stored high nibble and this byte.
  logic [7:0] hex_v;

  assign b        = in_i.data_byte;
  assign accept   = in_i.valid && !full_i;
  assign in_i.ready = !full_i;

  always_comb begin
    idle_n    = 1'b0;
    idle_kind = K_GRPSTART;
    idle_char = 8'h00;
    idle_mode = M_IDLE;
    priority if (b <= 8'd8 || (b >= 8'd10 && b <= 8'd31)) begin
      idle_n = 1'b0;
    end else if (b == 8'h7B) begin
      idle_n = 1'b1;
    end else if (b == 8'h7D) begin
      idle_n    = 1'b1;
      idle_kind = K_GRPEND;
    end else if (b == 8'h5C) begin
      idle_mode = M_BSL;
    end else begin
      idle_n    = 1'b1;
      idle_kind = K_TEXTCHAR;
      idle_char = b;
      idle_mode = M_TEXT;
    end
  end

  assign kw_hp  = (mode_q == M_PARAM);
  assign kw_mag = neg_q ? (~acc_q + 1'b1) : acc_q;
  assign kw_prm = kw_hp ? OUT_PARAM_W'(signed'(kw_mag)) : '0;

  always_comb begin
    hex_v = {hi_q, hex_val(b)};
    if (hex_v <= 8'd30) begin
      hex_v = hex_v + 8'd1;
    end
  end

  // Next state and the tokens of the current byte.
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    hi_d   = hi_q;
    n      = 2'd0;
    rec    = '0;
    if (in_i.end_of_input) begin
      n = 2'd1;
      rec.kind0 = K_EOF;
      if (mode_q == M_TEXT) begin
        n = 2'd2;
        rec.kind0 = K_TEXTEND;
        rec.kind1 = K_EOF;
      end else if (mode_q == M_NAME || mode_q == M_PARAM) begin
        n = 2'd2;
        rec.kind0     = K_KWEND;
        rec.kind1     = K_EOF;
        rec.has_param = kw_hp;
        rec.param     = kw_prm;
      end
      mode_d = M_IDLE;
      acc_d  = '0;
      neg_d  = 1'b0;
      hi_d   = 4'h0;
    end else begin
      unique case (mode_q)
        M_TEXT: begin
          if (b == 8'd10 || b == 8'd13 || b == 8'd0) begin
            n = 2'd0;
          end else if (b == 8'h5C || b == 8'h7B || b == 8'h7D) begin
            rec.kind0 = K_TEXTEND;
            rec.kind1 = idle_kind;
            rec.char1 = idle_char;
            n         = idle_n ? 2'd2 : 2'd1;
            mode_d    = idle_mode;
          end else begin
            n         = 2'd1;
            rec.kind0 = K_TEXTCHAR;
            rec.char0 = b;
          end
        end
        M_BSL: begin
          n      = 2'd1;
          mode_d = M_IDLE;
          if (is_alpha(b)) begin
            rec.kind0 = K_NAMECHAR;
            rec.char0 = b;
            mode_d    = M_NAME;
            acc_d     = '0;
            neg_d     = 1'b0;
          end else if (b == 8'h5C || b == 8'h7B || b == 8'h7D) begin
            rec.kind0 = K_ESCAPED;
            rec.char0 = b;
          end else if (b == 8'd9) begin
            rec.kind0 = K_TAB;
          end else if (b == 8'd10 || b == 8'd13) begin
            rec.kind0 = K_PAR;
          end else if (b >= 8'd1 && b <= 8'd31) begin
            rec.kind0 = K_EMPTYTEXT;
          end else if (b == 8'h27) begin
            n      = 2'd0;
            mode_d = M_HEX1;
            hi_d   = 4'h0;
          end else if (b == 8'h7C || b == 8'h7E || b == 8'h2D || b == 8'h5F ||
                       b == 8'h3A) begin
            // Symbol keyword: one name letter and a bare keyword end.
            n         = 2'd2;
            rec.kind0 = K_NAMECHAR;
            rec.char0 = b;
            rec.kind1 = K_KWEND;
          end else begin
            rec.kind0 = K_CTLSYM;
            rec.char0 = b;
          end
        end
        M_NAME, M_PARAM: begin
          if (mode_q == M_NAME && is_alpha(b)) begin
            n         = 2'd1;
            rec.kind0 = K_NAMECHAR;
            rec.char0 = b;
          end else if (is_digit(b)) begin
            mode_d = M_PARAM;
            if (mode_q == M_NAME) begin
              neg_d = 1'b0;
              acc_d = PARAM_WIDTH'(b[3:0]);
            end else begin
              // Multiply by ten and add the digit, wrapping at the width.
              acc_d = (acc_q << 3) + (acc_q << 1) + PARAM_WIDTH'(b[3:0]);
            end
          end else if (mode_q == M_NAME && b == 8'h2D) begin
            mode_d = M_PARAM;
            neg_d  = 1'b1;
            acc_d  = '0;
          end else begin
            rec.kind0     = K_KWEND;
            rec.has_param = kw_hp;
            rec.param     = kw_prm;
            if (b == 8'h20) begin
              n      = 2'd1;
              mode_d = M_IDLE;
            end else begin
              rec.kind1 = idle_kind;
              rec.char1 = idle_char;
              n         = idle_n ? 2'd2 : 2'd1;
              mode_d    = idle_mode;
            end
          end
        end
        M_HEX1: begin
          hi_d   = hex_val(b);
          mode_d = M_HEX2;
        end
        M_HEX2: begin
          n             = 2'd1;
          rec.kind0     = K_HEX;
          rec.has_param = 1'b1;
          rec.param     = OUT_PARAM_W'(hex_v);
          hi_d          = 4'h0;
          mode_d        = M_IDLE;
        end
        default: begin
          rec.kind0 = idle_kind;
          rec.char0 = idle_char;
          n         = idle_n ? 2'd1 : 2'd0;
          mode_d    = idle_mode;
        end
      endcase
    end
    rec.two = (n == 2'd2);
  end

  assign push_o = accept && (n != 2'd0);
  assign rec_o  = rec;

  // Lexing state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      hi_q   <= 4'h0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      hi_q   <= hi_d;
    end
  end

endmodule

/* design/rtftl_fifo.sv */
// Short queue of token records between the lexer front end and back end.
// Uses rtftl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtftl_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rtftl_pkg::token_rec_t rec_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output rtftl_pkg::token_rec_t rec_o
);
  import rtftl_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  token_rec_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ASSERT_AT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(FIFO_DEPTH), "queue count overflow")

endmodule

/* design/rtftl_back.sv */
// Back end of the RTF token lexer: unpacks each record into one or two
// result transactions from an output register. Uses rtftl_pkg, rtftl_if.
`include "assert_macros.svh"

module rtftl_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  rtftl_pkg::token_rec_t rec_i,
  output logic                  pop_o,
  rtftl_out_if.source           out_o
);
  import rtftl_pkg::*;

  token_rec_t hold_q;
  logic       valid_q;
  logic       pos_q;
  kind_e      kind;
  logic       last;
  logic       fire;
  logic       advance;

  assign kind = pos_q ? hold_q.kind1 : hold_q.kind0;
  assign last = pos_q || !hold_q.two;

  // Result fields come straight from the held record.
  assign out_o.valid      = valid_q;
  assign out_o.kind       = kind;
  assign out_o.char_value = pos_q ? hold_q.char1 : hold_q.char0;
  assign out_o.has_param  = hold_q.has_param && (kind == K_KWEND || kind == K_HEX);
  assign out_o.param      = out_o.has_param ? hold_q.param : '0;
  assign out_o.last       = last;

  assign fire    = valid_q && out_o.ready;
  assign advance = !valid_q || (fire && last);
  assign pop_o   = advance && !empty_i;

  // Payload register loads a new record when the current one is done.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hold_q <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 1'b0;
    end else if (fire && !last) begin
      pos_q <= 1'b1;
    end else if (advance) begin
      valid_q <= !empty_i;
      pos_q   <= 1'b0;
    end
  end

  `ASSERT_AT(a_second_token, clk_i, rst_ni, !pos_q || (valid_q && hold_q.two),
             "second token selected without a two-token record")

endmodule

/* design/rtf_token_lexer.sv */
// RTF token lexer: takes one document byte per input transaction and
// emits token transactions (kind, character, optional signed parameter).
// Input channel in_i carries data_byte and end_of_input; output channel
// out_o carries kind, char_value, has_param, param and last, where last
// marks the final token caused by one input byte.
// A byte is taken every cycle while the record queue has room; it leaves
// the front end's lexing state machine in the same cycle and reaches
// the output register by way of the record queue.
// A byte that causes two tokens holds the output register for both;
// bytes that cause none never reach it. Sustained output is one token
// per cycle while the receiver is ready, bounded by the single output register.
// While the receiver stalls, the four-entry record queue fills and then
// in_i.ready drops. Reset clears the lexing state, the queue and the
// output valid; an end_of_input byte also returns the lexer to idle.
// PARAM_WIDTH sets the wrap width of keyword parameters, which are
// sign-extended or cut to 32 bits on output.
module rtf_token_lexer #(
  parameter int PARAM_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtftl_in_if.sink     in_i,
  rtftl_out_if.source  out_o
);
  import rtftl_pkg::*;

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  token_rec_t push_rec;
  token_rec_t pop_rec;

  // Byte classification and lexing state.
  rtftl_front #(
    .PARAM_WIDTH(PARAM_WIDTH)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .rec_o (push_rec)
  );

  // Record queue decoupling the two ends.
  rtftl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rec_o  (pop_rec)
  );

  // Token output sequencing.
  rtftl_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .rec_i  (pop_rec),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

/* tb/rtf_token_lexer_checker.sv */
// Token checker for the RTF token lexer: watches both channels, predicts
// the token transactions for every accepted byte and compares them in order.
// Depends on rtftl_pkg (kind_e) and the channel interfaces in rtftl_if.sv.
module rtf_token_lexer_checker #(
  parameter int PARAM_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rtftl_in_if   in_mon_i,
  rtftl_out_if  out_mon_i,
  output int    fail_count_o,
  output int    pending_o
);
  import rtftl_pkg::*;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_TEXT,
    LX_ESC,
    LX_WORD,
    LX_NUM,
    LX_HEX_HI,
    LX_HEX_LO
  } lex_state_e;

  typedef struct {
    kind_e              kind;
    logic [7:0]         ch;
    logic               has_param;
    logic signed [31:0] prm;
    logic               last;
  } token_t;

  // Predicted lexer state.
  lex_state_e             state;
  logic [PARAM_WIDTH-1:0] num_acc;
  logic                   num_neg;
  logic                   num_seen;
  logic [3:0]             hex_hi;

  token_t staged[$];
  token_t exp_tokens[$];
  int     errors;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Anything that is not a hex digit decodes as zero.
  function automatic logic [3:0] nibble(logic [7:0] b);
    if (is_num(b)) return 4'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return 4'(b - 8'h57);
    if (b >= 8'h41 && b <= 8'h46) return 4'(b - 8'h37);
    return 4'h0;
  endfunction

  function automatic void clear_state();
    state    = LX_IDLE;
    num_acc  = '0;
    num_neg  = 1'b0;
    num_seen = 1'b0;
    hex_hi   = 4'h0;
  endfunction

  function automatic void put(kind_e k, logic [7:0] c = 8'h00, logic hp = 1'b0,
                              logic signed [31:0] p = '0);
    token_t t;
    t.kind      = k;
    t.ch        = c;
    t.has_param = hp;
    t.prm       = p;
    t.last      = 1'b0;
    staged = {staged, t};
  endfunction

  // Keyword end; the parameter wraps at PARAM_WIDTH and is sign-extended.
  function automatic void put_kwend();
    logic [PARAM_WIDTH-1:0]        mag;
    logic signed [PARAM_WIDTH-1:0] val;
    if (!num_seen) begin
      put(K_KWEND);
    end else begin
      mag = num_neg ? -num_acc : num_acc;
      val = signed'(mag);
      put(K_KWEND, 8'h00, 1'b1, 32'(val));
    end
  endfunction

  function automatic void between_tokens(logic [7:0] b);
    state = LX_IDLE;
    if (b <= 8'd8 || (b >= 8'd10 && b <= 8'd31)) return;
    if (b == CH_LBRACE) begin
      put(K_GRPSTART);
    end else if (b == CH_RBRACE) begin
      put(K_GRPEND);
    end else if (b == CH_BSL) begin
      state = LX_ESC;
    end else begin
      state = LX_TEXT;
      put(K_TEXTCHAR, b);
    end
  endfunction

  function automatic void after_backslash(logic [7:0] b);
    state = LX_IDLE;
    if (is_letter(b)) begin
      state    = LX_WORD;
      num_acc  = '0;
      num_neg  = 1'b0;
      num_seen = 1'b0;
      put(K_NAMECHAR, b);
    end else if (b == CH_BSL || b == CH_LBRACE || b == CH_RBRACE) begin
      put(K_ESCAPED, b);
    end else if (b >= 8'd1 && b <= 8'd31) begin
      if (b == CH_TAB) begin
        put(K_TAB);
      end else if (b == CH_LF || b == CH_CR) begin
        put(K_PAR);
      end else begin
        put(K_EMPTYTEXT);
      end
    end else if (b == CH_QUOTE) begin
      state  = LX_HEX_HI;
      hex_hi = 4'h0;
    end else if (b inside {CH_PIPE, CH_TILDE, CH_MINUS, CH_UNDER, CH_COLON}) begin
      // Symbol keywords close at once and swallow no space.
      put(K_NAMECHAR, b);
      put(K_KWEND);
    end else begin
      put(K_CTLSYM, b);
    end
  endfunction

  // A keyword is closed by a byte that belongs to neither name nor number.
  function automatic void end_word(logic [7:0] b);
    put_kwend();
    if (b == CH_SPACE) begin
      state = LX_IDLE;
    end else begin
      between_tokens(b);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b, logic eoi);
    logic [7:0] hexv;
    staged.delete();
    if (eoi) begin
      if (state == LX_TEXT) begin
        put(K_TEXTEND);
      end else if (state == LX_WORD || state == LX_NUM) begin
        put_kwend();
      end
      put(K_EOF);
      clear_state();
    end else begin
      case (state)
        LX_TEXT: begin
          if (!(b == CH_LF || b == CH_CR || b == 8'h00)) begin
            if (b == CH_BSL || b == CH_LBRACE || b == CH_RBRACE) begin
              put(K_TEXTEND);
              between_tokens(b);
            end else begin
              put(K_TEXTCHAR, b);
            end
          end
        end
        LX_ESC: after_backslash(b);
        LX_WORD: begin
          if (is_letter(b)) begin
            put(K_NAMECHAR, b);
          end else if (is_num(b)) begin
            num_seen = 1'b1;
            num_neg  = 1'b0;
            num_acc  = PARAM_WIDTH'(nibble(b));
            state    = LX_NUM;
          end else if (b == CH_MINUS) begin
            num_seen = 1'b1;
            num_neg  = 1'b1;
            num_acc  = '0;
            state    = LX_NUM;
          end else begin
            end_word(b);
          end
        end
        LX_NUM: begin
          if (is_num(b)) begin
            num_acc = num_acc * PARAM_WIDTH'(10) + PARAM_WIDTH'(nibble(b));
          end else begin
            end_word(b);
          end
        end
        LX_HEX_HI: begin
          hex_hi = nibble(b);
          state  = LX_HEX_LO;
        end
        LX_HEX_LO: begin
          // Values up to 30 are raised by one.
          hexv = {hex_hi, nibble(b)};
          if (hexv <= 8'd30) hexv = hexv + 8'd1;
          put(K_HEX, 8'h00, 1'b1, 32'(hexv));
          hex_hi = 4'h0;
          state  = LX_IDLE;
        end
        default: between_tokens(b);
      endcase
    end
    foreach (staged[i]) begin
      if (i == staged.size() - 1) staged[i].last = 1'b1;
      exp_tokens = {exp_tokens, staged[i]};
    end
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Predict on every accepted byte, compare every accepted token.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    token_t want;
    if (!rst_ni) begin
      clear_state();
      exp_tokens.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        lex_byte(in_mon_i.data_byte, in_mon_i.end_of_input);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (exp_tokens.size() == 0) begin
          $error("token transaction with no expectation: kind %0d", out_mon_i.kind);
          errors++;
        end else begin
          want = exp_tokens.pop_front();
          check_field("kind", longint'(want.kind), longint'(out_mon_i.kind));
          check_field("char_value", longint'(want.ch), longint'(out_mon_i.char_value));
          check_field("has_param", longint'(want.has_param),
                      longint'(out_mon_i.has_param));
          check_field("param", longint'(want.prm), longint'(out_mon_i.param));
          check_field("last", longint'(want.last), longint'(out_mon_i.last));
        end
      end
      fail_count_o <= errors;
      pending_o    <= exp_tokens.size();
    end
  end

endmodule

/* tb/rtf_token_lexer_tb.sv */
// Testbench top for the RTF token lexer: clock, reset, byte stimulus and
// random receiver stalls; the token checker does prediction and comparison.
// Depends on rtftl_pkg, rtftl_if.sv, rtf_token_lexer and its checker.
module rtf_token_lexer_tb;

  localparam int PARAM_WIDTH = 32;
  localparam int ITEMS       = 550;
  localparam int QUIET_FROM  = 460;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL        = 20;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  logic clk;
  logic rst_n;
  bit   calm;
  int   sent;
  int   fail_count;
  int   pending;
  int   idle_cycles;

  string hex_chars = "0123456789abcdefABCDEF";
  string sym_chars = "|~-_:";
  string esc_chars = "\\{}";
  string edge_nums[8] = '{"2147483647", "2147483648", "-2147483648", "4294967295",
                          "4294967296", "99999999999", "0", "-0"};

  rtftl_in_if  byte_ch ();
  rtftl_out_if token_ch ();

  rtf_token_lexer #(
    .PARAM_WIDTH(PARAM_WIDTH)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (token_ch)
  );

  rtf_token_lexer_checker #(
    .PARAM_WIDTH(PARAM_WIDTH)
  ) token_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon_i    (byte_ch),
    .out_mon_i   (token_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stall bursts, none begun while the stream is calm.
  initial begin
    int stall;
    stall = 0;
    token_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && stall == 0 && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 18);
      end
      if (stall > 0) begin
        token_ch.ready <= 1'b0;
        stall--;
      end else begin
        token_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // One byte transaction, preceded now and then by a gap of idle cycles.
  task automatic send_byte(input logic [7:0] b, input logic eoi = 1'b0);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      byte_ch.valid        <= 1'b0;
      byte_ch.data_byte    <= 8'($urandom);
      byte_ch.end_of_input <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= b;
    byte_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] l;
    l = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 1) == 1) ? 8'h41 + l : 8'h61 + l;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
  endfunction

  // Short hand-picked document covering every token kind and corner case.
  task automatic directed_part();
    send_byte(8'h01);
    send_str("{A");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_str("}");
    send_str("\\z- ");
    send_str("\\q-5{");
    send_str("\\'0Z\\'ff");
    send_str("\\|\\*\\{");
    send_byte(CH_BSL);
    send_byte(8'h00);
    send_byte(CH_BSL);
    send_byte(8'h09);
    send_byte(CH_BSL);
    send_byte(8'h0D);
    send_byte(CH_BSL);
    send_byte(8'h1F);
    // End of input with text open, keyword open, hex pending, lone backslash.
    send_str("k");
    send_byte(8'h00, 1'b1);
    send_str("\\w9");
    send_byte(8'hFF, 1'b1);
    send_str("\\'a");
    send_byte(8'h00, 1'b1);
    send_byte(CH_BSL);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic send_control_word();
    int n;
    send_byte(CH_BSL);
    n = $urandom_range(1, 6);
    repeat (n) send_byte(rand_letter());
    case ($urandom_range(0, 9))
      4: send_str($sformatf("%0d", $urandom_range(0, 999)));
      5: send_str($sformatf("-%0d", $urandom_range(0, 99999)));
      6: send_byte(CH_MINUS);
      7: send_str(edge_nums[$urandom_range(0, 7)]);
      8, 9: begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'h30 + 8'($urandom_range(0, 9)));
      end
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: send_byte(CH_SPACE);
      1: send_byte(8'($urandom));
      default: ;
    endcase
  endtask

  // One random token, mostly well formed, with some noise mixed in.
  task automatic send_token();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(8'($urandom));
          end else begin
            send_byte(8'($urandom_range(8'h20, 8'h7A)));
          end
        end
      end
      6: send_byte(CH_LBRACE);
      7: send_byte(CH_RBRACE);
      8, 9, 10, 11: send_control_word();
      12, 13: begin
        send_byte(CH_BSL);
        send_byte(CH_QUOTE);
        send_byte(rand_hex_char());
        send_byte(rand_hex_char());
      end
      14: begin
        send_byte(CH_BSL);
        send_byte(esc_chars[$urandom_range(0, 2)]);
      end
      15: begin
        send_byte(CH_BSL);
        send_byte(sym_chars[$urandom_range(0, 4)]);
      end
      16: begin
        send_byte(CH_BSL);
        send_byte(8'($urandom));
      end
      17: send_byte(8'($urandom));
      18: send_byte(8'($urandom_range(0, 31)));
      default: send_byte(8'($urandom), 1'b1);
    endcase
  endtask

  // Stimulus and verdict.
  initial begin
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = 8'h00;
    byte_ch.end_of_input = 1'b0;
    rst_n       = 1'b0;
    calm        = 1'b0;
    sent        = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_part();
    while (sent < ITEMS) begin
      if (sent >= QUIET_FROM) begin
        calm = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        calm = ~calm;
      end
      send_token();
    end
    byte_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
